@@ rtl/core/deq_pkg.sv @@
// Shared operation and status codes for the double-ended queue.
package deq_pkg;

  // Operation codes carried on the action input
  typedef enum logic [2:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_QUERY      = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ rtl/core/deq_ram.sv @@
// Ring store: one write port, one registered read port, same-entry write forwarding.
module deq_ram #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [DATA_WIDTH-1:0]         wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_i,
  output logic [DATA_WIDTH-1:0]         rd_data_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [DATA_WIDTH-1:0] fwd_data_q;
  logic                  fwd_sel_q;

  // Write the pushed entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the front entry; remember a write to the same entry in this cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
      fwd_sel_q  <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // Forward the new data over the stale array read
  assign rd_data_o = fwd_sel_q ? fwd_data_q : rd_data_q;

endmodule

@@ rtl/core/deq_ctrl.sv @@
// Index and count control: decodes operations, updates front and fill, drives the store.
module deq_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [2:0]                    action_i,
  input  logic [DATA_WIDTH-1:0]         value_i,
  output logic                          wr_en_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output logic [DATA_WIDTH-1:0]         wr_data_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_o,
  output logic                          valid_o,
  output deq_pkg::status_e              status_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = AW + 1;
  localparam logic [SW-1:0] DepthS   = SW'(DEPTH);
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic              valid_q;
  deq_pkg::status_e  status_q, status_d;

  logic              is_full;
  logic              is_empty;
  logic [SW-1:0]     rear_sum;
  logic [AW-1:0]     rear_idx;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;

  assign is_full  = (count_q == DepthCnt);
  assign is_empty = (count_q == '0);

  // Slot past the rear, wrapped with one compare and subtract
  assign rear_sum = {1'b0, front_q} + SW'(count_q);
  assign rear_idx = (rear_sum >= DepthS) ? AW'(rear_sum - DepthS) : AW'(rear_sum);

  // Neighbors of the front slot
  assign front_dec = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AW'(1);

  // Decode the operation into the next front, fill and store write
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    status_d  = deq_pkg::ST_DONE;
    wr_en_o   = 1'b0;
    wr_addr_o = rear_idx;
    unique case (deq_pkg::action_e'(action_i))
      deq_pkg::ACT_PUSH_REAR: begin
        if (is_full) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en_o = accept_i;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::ACT_PUSH_FRONT: begin
        wr_addr_o = front_dec;
        if (is_full) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          wr_en_o = accept_i;
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (is_empty) begin
          status_d = deq_pkg::ST_EMPTY;
        end else begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      deq_pkg::ACT_POP_REAR: begin
        if (is_empty) begin
          status_d = deq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status_d = deq_pkg::ST_DONE;
      end
    endcase
  end

  assign wr_data_o = value_i;
  // Read the front as it stands after this transaction
  assign rd_addr_o = front_d;

  // Advance the queue state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= deq_pkg::ST_DONE;
    end else begin
      valid_q <= accept_i;
      if (accept_i) begin
        front_q  <= front_d;
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  assign valid_o  = valid_q;
  assign status_o = status_q;
  assign count_o  = count_q;

  // Fill never passes the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("fill count above depth");

  // Front index stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) front_q <= LastIdx)
    else $error("front index out of range");

  // A refused push leaves the queue full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == deq_pkg::ST_FULL) |-> count_q == DepthCnt)
    else $error("push refused while not full");

  // A refused pop leaves the queue empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == deq_pkg::ST_EMPTY) |-> count_q == '0)
    else $error("pop refused while not empty");

  // Fill moves by at most one per transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> (count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
                  || count_q == $past(count_q) - CW'(1)))
    else $error("fill count jumped");

endmodule

@@ rtl/core/double_ended_queue.sv @@
// Double-ended queue top level: command port, ring store and result outputs.
//
// A transaction is taken at every clock edge where start is high; busy stays
// low, so one push, pop or query can be issued every cycle. Each transaction
// yields exactly one result in the next cycle, shown for a single cycle with
// done_o high; the receiver cannot stall it. The delay comes from the
// registered read port of the ring store, which returns the front entry
// after the operation; a push that lands on the front entry is forwarded.
// A push into a full queue (status 2) or a pop from an empty one (status 1)
// leaves the queue unchanged. front_value_o reads zero when the queue is empty.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    action_i,
  input  logic [DATA_WIDTH-1:0]         value_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [DATA_WIDTH-1:0]         front_value_o,
  output logic                          is_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  res_valid;
  deq_pkg::status_e      res_status;
  logic [CW-1:0]         res_count;

  // Take a command every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (action_i),
    .value_i   (value_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .valid_o   (res_valid),
    .status_o  (res_status),
    .count_o   (res_count)
  );

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Drive the result; mask the front value when nothing is held
  assign done_o        = res_valid;
  assign status_o      = res_status;
  assign is_empty_o    = (res_count == '0);
  assign entry_count_o = res_count;
  assign front_value_o = (res_count == '0) ? '0 : rd_data;

endmodule
